>>> rtl/arp_reply_builder_core_macros.svh
// Assertion macros for the ARP reply builder RTL.
`ifndef ARP_REPLY_BUILDER_CORE_MACROS_SVH
`define ARP_REPLY_BUILDER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ARB_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`define ARB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ARB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ARB_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`define ARB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ARB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/arb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package arb_pkg;

    localparam int MacW = 48;
    localparam int IpW = 32;
    localparam int SenderW = 80;
    localparam int PosW = 6;
    localparam int CfgDataW = 48;

    localparam logic [PosW-1:0] ReqMacFirst = 6'd6;
    localparam logic [PosW-1:0] ReqMacEnd = 6'd12;
    localparam logic [PosW-1:0] SenderFirst = 6'd22;
    localparam logic [PosW-1:0] SenderEnd = 6'd32;
    localparam logic [PosW-1:0] TargetIpFirst = 6'd38;
    localparam logic [PosW-1:0] LastNeeded = 6'd41;
    localparam logic [PosW-1:0] PosMax = 6'd42;
    localparam logic [PosW-1:0] ReplyLastIdx = 6'd41;

    // Configuration register indexes.
    localparam logic RegMyMac = 1'b0;
    localparam logic RegMyIp = 1'b1;

    localparam logic [IpW-1:0] MyIpReset = 32'hC0A8010A;

    typedef struct packed {
        logic [MacW-1:0]    requester_mac;
        logic [SenderW-1:0] sender_mac_ip;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic [7:0] ip_byte(input logic [IpW-1:0] ip, input logic [1:0] idx);
        logic [IpW-1:0] sh;
        sh = ip >> (8 * (3 - int'(idx)));
        return sh[7:0];
    endfunction

    function automatic logic [7:0] arp_fixed(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0: r = 8'h08;
            4'd1: r = 8'h06;
            4'd2: r = 8'h00;
            4'd3: r = 8'h01;
            4'd4: r = 8'h08;
            4'd5: r = 8'h00;
            4'd6: r = 8'h06;
            4'd7: r = 8'h04;
            4'd8: r = 8'h00;
            4'd9: r = 8'h02;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] reply_byte(
        input logic [PosW-1:0]    k,
        input logic [MacW-1:0]    req,
        input logic [SenderW-1:0] snd,
        input logic [MacW-1:0]    mac,
        input logic [IpW-1:0]     ip
    );
        logic [7:0]       r;
        logic [MacW-1:0]  mac_sh;
        logic [SenderW-1:0] snd_sh;
        int i;
        i = int'(k);
        r = 8'h00;
        mac_sh = '0;
        snd_sh = '0;
        case (k) inside
            [6'd0:6'd5]: begin
                mac_sh = req >> (8 * (5 - i));
                r = mac_sh[7:0];
            end
            [6'd6:6'd11]: begin
                mac_sh = mac >> (8 * (11 - i));
                r = mac_sh[7:0];
            end
            [6'd12:6'd21]: r = arp_fixed(4'(i - 12));
            [6'd22:6'd27]: begin
                mac_sh = mac >> (8 * (27 - i));
                r = mac_sh[7:0];
            end
            [6'd28:6'd31]: r = ip_byte(ip, 2'(i - 28));
            [6'd32:6'd41]: begin
                snd_sh = snd >> (8 * (41 - i));
                r = snd_sh[7:0];
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/arb_front.sv
`timescale 1ns / 1ps
`default_nettype none

module arb_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [7:0]                  rx_byte,
    input  wire logic                        rx_last,
    input  wire logic [arb_pkg::IpW-1:0]     my_ip,
    output arb_pkg::desc_t                   desc,
    output logic                             desc_push
);

    logic [arb_pkg::PosW-1:0]    pos_reg, pos_next;
    logic                        mismatch_reg, mismatch_next;
    logic [arb_pkg::MacW-1:0]    req_mac_reg;
    logic [arb_pkg::SenderW-1:0] sender_reg;
    logic                        in_req, in_sender, in_target, byte_differs, mismatch_now;
    logic [1:0]                  ip_idx;

    assign in_req    = (pos_reg >= arb_pkg::ReqMacFirst) && (pos_reg < arb_pkg::ReqMacEnd);
    assign in_sender = (pos_reg >= arb_pkg::SenderFirst) && (pos_reg < arb_pkg::SenderEnd);
    assign in_target = (pos_reg >= arb_pkg::TargetIpFirst) && (pos_reg < arb_pkg::PosMax);
    assign ip_idx    = 2'(pos_reg - arb_pkg::TargetIpFirst);
    assign byte_differs = rx_byte != arb_pkg::ip_byte(my_ip, ip_idx);
    assign mismatch_now = mismatch_reg || (in_target && byte_differs);

    always_comb
    begin
        pos_next = pos_reg;
        mismatch_next = mismatch_reg;
        if (accept)
        begin
            if (rx_last)
            begin
                pos_next = '0;
                mismatch_next = 1'b0;
            end
            else
            begin
                mismatch_next = mismatch_now;
                if (pos_reg < arb_pkg::PosMax)
                    pos_next = pos_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            mismatch_reg <= 1'b0;
            req_mac_reg <= '0;
            sender_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            mismatch_reg <= mismatch_next;
            // Captured fields shift in, so the first byte ends up most significant.
            if (accept && in_req)
                req_mac_reg <= {req_mac_reg[arb_pkg::MacW-9:0], rx_byte};
            if (accept && in_sender)
                sender_reg <= {sender_reg[arb_pkg::SenderW-9:0], rx_byte};
        end
    end

    assign desc_push = accept && rx_last && (pos_reg >= arb_pkg::LastNeeded) && !mismatch_now;
    assign desc.requester_mac = req_mac_reg;
    assign desc.sender_mac_ip = sender_reg;

endmodule

`default_nettype wire

>>> rtl/arb_desc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module arb_desc_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire arb_pkg::desc_t wr_data,
    input  wire logic           pop,
    output arb_pkg::desc_t      rd_data,
    output arb_pkg::fifo_stat_t stat
);

    arb_pkg::desc_t mem [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign do_push = push && (cnt_reg != 2'd2);
    assign do_pop  = pop && (cnt_reg != 2'd0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= !wptr_reg;
            if (do_pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    assign rd_data = mem[rptr_reg];
    assign stat.full = cnt_reg == 2'd2;
    assign stat.empty = cnt_reg == 2'd0;

endmodule

`default_nettype wire

>>> rtl/arb_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "arp_reply_builder_core_macros.svh"

module arb_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire arb_pkg::desc_t          desc,
    input  wire logic                    desc_empty,
    output logic                         desc_pop,
    input  wire logic [arb_pkg::MacW-1:0] my_mac,
    input  wire logic [arb_pkg::IpW-1:0]  my_ip,
    output logic [7:0]                   tx_byte,
    output logic                         tx_last,
    output logic                         empty,
    input  wire logic                    pop
);

    logic [arb_pkg::PosW-1:0] idx_reg;
    logic [8:0] out_mem [2];
    logic       out_wptr_reg, out_rptr_reg;
    logic [1:0] out_cnt_reg, out_cnt_next;
    logic       room, gen, out_pop, gen_last;
    logic [7:0] gen_byte;

    assign room = out_cnt_reg != 2'd2;
    assign gen = !desc_empty && room;
    assign gen_last = idx_reg == arb_pkg::ReplyLastIdx;
    assign desc_pop = gen && gen_last;
    assign out_pop = pop && (out_cnt_reg != 2'd0);
    assign gen_byte = arb_pkg::reply_byte(idx_reg, desc.requester_mac, desc.sender_mac_ip,
                                          my_mac, my_ip);

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (gen && !out_pop)
            out_cnt_next = out_cnt_reg + 2'd1;
        else if (out_pop && !gen)
            out_cnt_next = out_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (gen)
            out_mem[out_wptr_reg] <= {gen_last, gen_byte};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            out_wptr_reg <= 1'b0;
            out_rptr_reg <= 1'b0;
            out_cnt_reg <= 2'd0;
        end
        else
        begin
            if (gen)
            begin
                idx_reg <= gen_last ? '0 : idx_reg + 6'd1;
                out_wptr_reg <= !out_wptr_reg;
            end
            if (out_pop)
                out_rptr_reg <= !out_rptr_reg;
            out_cnt_reg <= out_cnt_next;
        end
    end

    assign {tx_last, tx_byte} = out_mem[out_rptr_reg];
    assign empty = out_cnt_reg == 2'd0;

    `ARB_ASSERT_NEVER(a_idx_range, clk, rst_n, idx_reg > arb_pkg::ReplyLastIdx, "reply index out of range")
    `ARB_ASSERT_NEVER(a_out_cnt, clk, rst_n, out_cnt_reg == 2'd3, "output stage overflow")
    `ARB_ASSERT_IMPLIES(a_idle_idx, clk, rst_n, desc_empty, idx_reg == '0, "reply index moved without a descriptor")
    `ARB_ASSERT_NEXT(a_pop_wraps, clk, rst_n, desc_pop, idx_reg == '0, "index did not wrap after last reply byte")

endmodule

`default_nettype wire

>>> rtl/arp_reply_builder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  ----------------------------------
// rx        in         push / full            rx_byte[7:0], rx_last
// tx        out        empty / pop            tx_byte[7:0], tx_last
// cfg       in         cfg_we (no wait)       cfg_index[0], cfg_data[47:0]
//
// Received bytes are taken one per cycle while full is low; full rises only while two replies wait.
// A matching frame's last byte queues a reply descriptor at its accepting edge; the
// back end then writes the first beat into its output buffer, which drives the result
// ports, and the other 41 beats follow at one per cycle while the receiver keeps popping.
// Reply throughput is set by the single-byte output path that carries each reply.
// Reset clears the byte position, the queues and my_mac, and sets my_ip to 192.168.1.10.

module arp_reply_builder_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [7:0]                   rx_byte,
    input  wire logic                         rx_last,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [7:0]                        tx_byte,
    output logic                              tx_last,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [arb_pkg::CfgDataW-1:0] cfg_data
);

    logic [arb_pkg::MacW-1:0] my_mac_reg;
    logic [arb_pkg::IpW-1:0]  my_ip_reg;
    arb_pkg::desc_t           front_desc, back_desc;
    arb_pkg::fifo_stat_t      desc_stat;
    logic                     accept, desc_push, desc_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_mac_reg <= '0;
            my_ip_reg <= arb_pkg::MyIpReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                arb_pkg::RegMyMac: my_mac_reg <= cfg_data;
                arb_pkg::RegMyIp:  my_ip_reg <= cfg_data[arb_pkg::IpW-1:0];
                default: ;
            endcase
        end
    end

    assign full = desc_stat.full;
    assign accept = push && !full;

    arb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .rx_last   (rx_last),
        .my_ip     (my_ip_reg),
        .desc      (front_desc),
        .desc_push (desc_push)
    );

    arb_desc_fifo u_desc_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (desc_push),
        .wr_data (front_desc),
        .pop     (desc_pop),
        .rd_data (back_desc),
        .stat    (desc_stat)
    );

    arb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (back_desc),
        .desc_empty (desc_stat.empty),
        .desc_pop   (desc_pop),
        .my_mac     (my_mac_reg),
        .my_ip      (my_ip_reg),
        .tx_byte    (tx_byte),
        .tx_last    (tx_last),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

`default_nettype wire

>>> sim/arp_reply_builder_core_tb.sv
`timescale 1ns / 1ps

module arp_reply_builder_core_tb;

    localparam int StuckLimit = 5000;
    localparam int SettleCycles = 60;
    localparam int ReplyBytes = 42;
    localparam logic [79:0] ArpReplyHeader = 80'h0806_0001_0800_0604_0002;

    typedef struct {
        logic [7:0] octet;
        logic       last;
    } reply_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [7:0] rx_byte = 8'h00;
    logic rx_last = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic [7:0] tx_byte;
    logic tx_last;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [arb_pkg::CfgDataW-1:0] cfg_data = '0;

    // Local copy of the station registers and the receive-side capture state.
    logic [47:0] station_mac;
    logic [31:0] station_ip;
    logic [5:0]  rx_pos;
    logic [47:0] requester_cap;
    logic [79:0] sender_cap;
    logic        target_differs;

    reply_beat_t pending_reply[$];
    logic [7:0]  frame_bytes[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;
    int frames_sent = 0;
    int beats_checked = 0;
    int replies_seen = 0;
    int mismatches = 0;

    arp_reply_builder_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .rx_byte(rx_byte),
        .rx_last(rx_last),
        .empty(empty),
        .pop(pop),
        .tx_byte(tx_byte),
        .tx_last(tx_last),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
    begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [7:0] reply_octet(input int k);
        if (k < 6)
            return requester_cap[8*(5-k) +: 8];
        if (k < 12)
            return station_mac[8*(11-k) +: 8];
        if (k < 22)
            return ArpReplyHeader[8*(21-k) +: 8];
        if (k < 28)
            return station_mac[8*(27-k) +: 8];
        if (k < 32)
            return station_ip[8*(31-k) +: 8];
        return sender_cap[8*(41-k) +: 8];
    endfunction

    function automatic void absorb_rx_byte(input logic [7:0] b, input logic last);
        int p;
        reply_beat_t beat;
        p = int'(rx_pos);
        if (p >= 6 && p < 12)
            requester_cap[8*(11-p) +: 8] = b;
        else if (p >= 22 && p < 32)
            sender_cap[8*(31-p) +: 8] = b;
        else if (p >= 38 && p < 42)
        begin
            // Each target byte is compared with the address as it stands now.
            if (b != station_ip[8*(41-p) +: 8])
                target_differs = 1'b1;
        end
        if (last)
        begin
            if (rx_pos >= arb_pkg::LastNeeded && !target_differs)
            begin
                for (int k = 0; k < ReplyBytes; k++)
                begin
                    beat.octet = reply_octet(k);
                    beat.last = (k == ReplyBytes - 1);
                    pending_reply.push_back(beat);
                end
            end
            rx_pos = '0;
            target_differs = 1'b0;
        end
        else if (rx_pos < arb_pkg::PosMax)
            rx_pos = rx_pos + 6'd1;
    endfunction

    always @(posedge clk)
    begin : reply_check
        reply_beat_t want;
        if (rst_n && pop && !empty)
        begin
            beats_checked++;
            if (pending_reply.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d arrived with nothing expected: byte %02h last %b",
                             beats_checked, tx_byte, tx_last);
            end
            else
            begin
                want = pending_reply.pop_front();
                if (tx_byte !== want.octet || tx_last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: expected byte %02h last %b, got byte %02h last %b",
                                 beats_checked, want.octet, want.last, tx_byte, tx_last);
                end
                if (want.last)
                    replies_seen++;
            end
        end
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < StuckLimit)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
                stuck = 0;
            else
                stuck++;
        end
        $display("timeout: no beat moved for %0d cycles", StuckLimit);
        $display("status: fail");
        $finish;
    end

    // All tasks below start and end just after a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        rx_byte = b;
        rx_last = last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        absorb_rx_byte(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame_range(input int first, input int stop);
        for (int i = first; i < stop; i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        if (stop == frame_bytes.size())
            frames_sent++;
    endtask

    task automatic wait_drained();
        push = 1'b0;
        while (pending_reply.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [47:0] val);
        wait_drained();
        repeat (8) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        if (idx == arb_pkg::RegMyMac)
            station_mac = val;
        else
            station_ip = val[31:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic build_request(input logic [31:0] target_ip, input int len);
        logic [47:0] src_mac;
        logic [31:0] sender_ip;
        src_mac = {16'($urandom), $urandom};
        sender_ip = $urandom;
        frame_bytes.delete();
        repeat (6) frame_bytes.push_back(8'hFF);
        for (int i = 5; i >= 0; i--)
            frame_bytes.push_back(src_mac[8*i +: 8]);
        // Ethertype, then htype, ptype, sizes and a request opcode.
        for (int i = 9; i >= 0; i--)
            frame_bytes.push_back(ArpReplyHeader[8*i +: 8] ^ ((i == 0) ? 8'h03 : 8'h00));
        for (int i = 5; i >= 0; i--)
            frame_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : src_mac[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            frame_bytes.push_back(sender_ip[8*i +: 8]);
        repeat (6) frame_bytes.push_back(8'h00);
        for (int i = 3; i >= 0; i--)
            frame_bytes.push_back(target_ip[8*i +: 8]);
        while (frame_bytes.size() < len)
            frame_bytes.push_back(8'($urandom));
        while (frame_bytes.size() > len)
            void'(frame_bytes.pop_back());
    endtask

    task automatic fill_frame(input logic [7:0] value, input int len);
        frame_bytes.delete();
        repeat (len) frame_bytes.push_back(value);
    endtask

    task automatic test_default_registers();
        build_request(32'hC0A8010A, ReplyBytes);
        send_frame_range(0, frame_bytes.size());
        wait_drained();
    endtask

    task automatic test_short_frames();
        fill_frame(8'hA5, 1);
        send_frame_range(0, 1);
        build_request(station_ip, ReplyBytes - 1);
        send_frame_range(0, frame_bytes.size());
        wait_drained();
    endtask

    task automatic test_field_extremes();
        write_reg(arb_pkg::RegMyMac, 48'hFFFF_FFFF_FFFF);
        write_reg(arb_pkg::RegMyIp, 48'hFFFF_FFFF_FFFF);
        fill_frame(8'hFF, ReplyBytes);
        send_frame_range(0, ReplyBytes);
        write_reg(arb_pkg::RegMyMac, 48'h0);
        write_reg(arb_pkg::RegMyIp, 48'h0);
        fill_frame(8'h00, ReplyBytes);
        send_frame_range(0, ReplyBytes);
        wait_drained();
    endtask

    task automatic test_target_mismatch();
        write_reg(arb_pkg::RegMyIp, {16'($urandom), $urandom});
        build_request(station_ip ^ 32'h0000_0001, ReplyBytes);
        send_frame_range(0, ReplyBytes);
        wait_drained();
    endtask

    task automatic test_long_frame();
        build_request(station_ip, 48);
        send_frame_range(0, 48);
        wait_drained();
    endtask

    // The address changes between the second and third target byte; the first
    // half must match the old address and the reply must carry the new one.
    task automatic test_register_timing();
        logic [31:0] next_ip;
        next_ip = $urandom;
        build_request({station_ip[31:16], next_ip[15:0]}, ReplyBytes);
        send_frame_range(0, 40);
        write_reg(arb_pkg::RegMyMac, {16'($urandom), $urandom});
        write_reg(arb_pkg::RegMyIp, {16'($urandom), next_ip});
        send_frame_range(40, ReplyBytes);
        wait_drained();
    endtask

    task automatic send_random_frame();
        int kind;
        int lane;
        kind = $urandom_range(0, 99);
        if (kind < 60)
            build_request(station_ip, $urandom_range(42, 64));
        else if (kind < 75)
        begin
            lane = $urandom_range(0, 3);
            build_request(station_ip ^ (32'($urandom_range(1, 255)) << (8 * lane)),
                          $urandom_range(42, 64));
        end
        else if (kind < 90)
            build_request(station_ip, $urandom_range(1, 41));
        else
        begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 64)) frame_bytes.push_back(8'($urandom));
        end
        send_frame_range(0, frame_bytes.size());
    endtask

    task automatic test_traffic(input int idle_pct, input int stall_pct, input int budget);
        int start;
        start = bytes_sent;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (bytes_sent - start < budget)
            send_random_frame();
        wait_drained();
    endtask

    initial
    begin
        station_mac = '0;
        station_ip = arb_pkg::MyIpReset;
        rx_pos = '0;
        requester_cap = '0;
        sender_cap = '0;
        target_differs = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_default_registers();
        test_short_frames();

        send_idle_pct = 78;
        recv_stall_pct = 0;
        test_field_extremes();
        test_target_mismatch();

        send_idle_pct = 0;
        recv_stall_pct = 78;
        test_long_frame();
        test_register_timing();

        write_reg(arb_pkg::RegMyMac, {16'($urandom), $urandom});
        write_reg(arb_pkg::RegMyIp, {16'($urandom), arb_pkg::MyIpReset});
        test_traffic(7, 7, 30);

        wait_drained();
        repeat (SettleCycles) @(negedge clk);
        if (pending_reply.size() != 0)
        begin
            mismatches += pending_reply.size();
            $display("%0d reply beats never arrived", pending_reply.size());
        end
        $display("Sent %0d bytes in %0d frames: directed cases with no idling, sender idling",
                 bytes_sent, frames_sent);
        $display("and receiver stalling, then random frames with light idling on both sides.");
        $display("Checked %0d reply beats in %0d replies; %0d mismatches.",
                 beats_checked, replies_seen, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
